// File: hdl/nst_pkg.sv
// ----------------------------------------------------------------------------
// nst_pkg: shared types, constants and helpers for the nine-slice axis tiler.
// Holds the repeat-mode codes, the tile side-band record, the per-lane
// divider record and the saturation and division-step functions.
// ----------------------------------------------------------------------------
package nst_pkg;

   // Fixed-point fraction bits of every coordinate.
   localparam int FRAC_BITS = 8;

   // Repeat-mode codes.
   localparam logic [1:0] MODE_STRETCH = 2'd0;
   localparam logic [1:0] MODE_REPEAT  = 2'd1;
   localparam logic [1:0] MODE_ROUND   = 2'd2;
   localparam logic [1:0] MODE_SPACE   = 2'd3;

   // Output saturation limits.
   localparam logic signed [23:0] DEST_MIN = 24'sh800000;
   localparam logic signed [23:0] DEST_MAX = 24'sh7FFFFF;
   localparam logic [23:0]        SRC_MAX  = 24'hFFFF00;

   // Setup divider width, and the widths of the per-tile divider lanes.
   localparam int SDIV_W = 25;
   localparam int QW     = 25;
   localparam int DW     = 24;
   localparam int NW     = 48;

   // Side-band data that travels with a tile through the pipeline.
   typedef struct packed {
      logic signed [23:0] dlo;
      logic signed [23:0] dhi;
      logic [23:0]        s0;
      logic               last;
      logic               trunc;
      logic               empty;
      logic               lenz;
   } tile_side_type;

   // One lane of the pipelined restoring divider.
   typedef struct packed {
      logic [DW-1:0] rem;
      logic [QW-1:0] bits;
      logic [QW-1:0] q;
   } lane_type;

   // Load a numerator into a lane. The quotient fits in QW bits, so the
   // bits above them are already below the divisor.
   function automatic lane_type lane_init(input logic [NW-1:0] n);
      lane_type r;
      r.rem  = {1'b0, n[NW-1:QW]};
      r.bits = n[QW-1:0];
      r.q    = '0;
      return r;
   endfunction

   // One quotient bit: shift in the next numerator bit and compare-subtract.
   function automatic lane_type div_step(input lane_type l, input logic [DW-1:0] d);
      lane_type      r;
      logic [DW:0]   t;
      t      = {l.rem, l.bits[QW-1]};
      r.bits = {l.bits[QW-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
         r.rem = DW'(t - {1'b0, d});
         r.q   = {l.q[QW-2:0], 1'b1};
      end else begin
         r.rem = t[DW-1:0];
         r.q   = {l.q[QW-2:0], 1'b0};
      end
      return r;
   endfunction

   // Saturate a wide destination coordinate to 24 signed bits.
   function automatic logic signed [23:0] sat_dest(input logic signed [31:0] v);
      logic signed [23:0] r;
      if (v < -32'sd8388608) begin
         r = DEST_MIN;
      end else if (v > 32'sd8388607) begin
         r = DEST_MAX;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

   // Source start plus interpolated offset, saturated to the source range.
   function automatic logic [23:0] sat_src(input logic [23:0] s0, input logic [QW-1:0] q);
      logic [25:0] sum;
      logic [23:0] r;
      sum = {2'b00, s0} + {1'b0, q};
      if (sum > {2'b00, SRC_MAX}) begin
         r = SRC_MAX;
      end else begin
         r = sum[23:0];
      end
      return r;
   endfunction

endpackage

// File: hdl/nst_seq_div.sv
// ----------------------------------------------------------------------------
// nst_seq_div: iterative unsigned divider for tile count and width setup.
// Restoring division, one quotient bit per cycle; a one-cycle done pulse
// marks a valid quotient.
// ----------------------------------------------------------------------------
module nst_seq_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [nst_pkg::SDIV_W-1:0] num,
   input  logic [nst_pkg::SDIV_W-1:0] den,
   output logic                       done,
   output logic [nst_pkg::SDIV_W-1:0] quo
);

   localparam int W  = nst_pkg::SDIV_W;
   localparam int CW = $clog2(W);

   logic          busy_ff;
   logic          done_ff;
   logic [CW-1:0] cnt_ff;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  den_ff;
   logic [W:0]    trial;

   // Shift the next numerator bit into the remainder and compare-subtract.
   always_comb begin
      trial = {rem_ff, quo_ff[W-1]};
      if (trial >= {1'b0, den_ff}) begin
         rem_in = W'(trial - {1'b0, den_ff});
         quo_in = {quo_ff[W-2:0], 1'b1};
      end else begin
         rem_in = trial[W-1:0];
         quo_in = {quo_ff[W-2:0], 1'b0};
      end
   end

   // Control: busy flag, bit counter and done pulse.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: remainder, numerator/quotient shift register and divisor.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= num;
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// File: hdl/nst_div_pipe.sv
// ----------------------------------------------------------------------------
// nst_div_pipe: pipelined two-lane divider for source interpolation.
// Each stage resolves one quotient bit of both the low and the high source
// offset; the tile side-band and valid bit travel alongside.
// ----------------------------------------------------------------------------
module nst_div_pipe (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          ce,
   input  logic                          in_valid,
   input  nst_pkg::tile_side_type        in_side,
   input  logic [nst_pkg::DW-1:0]        in_den,
   input  logic [nst_pkg::NW-1:0]        in_num_lo,
   input  logic [nst_pkg::NW-1:0]        in_num_hi,
   output logic                          out_valid,
   output nst_pkg::tile_side_type        out_side,
   output logic [nst_pkg::QW-1:0]        out_q_lo,
   output logic [nst_pkg::QW-1:0]        out_q_hi
);

   localparam int QW = nst_pkg::QW;

   logic [QW-1:0]             v_ff;
   nst_pkg::tile_side_type    side_ff [QW];
   logic [nst_pkg::DW-1:0]    den_ff  [QW];
   nst_pkg::lane_type         lo_ff   [QW];
   nst_pkg::lane_type         hi_ff   [QW];

   // Valid bits shift with the stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (ce) begin
         v_ff <= {v_ff[QW-2:0], in_valid};
      end
   end

   // One quotient bit per stage for both lanes.
   always_ff @(posedge clock) begin
      if (ce) begin
         lo_ff[0]   <= nst_pkg::div_step(nst_pkg::lane_init(in_num_lo), in_den);
         hi_ff[0]   <= nst_pkg::div_step(nst_pkg::lane_init(in_num_hi), in_den);
         den_ff[0]  <= in_den;
         side_ff[0] <= in_side;
         for (int s = 1; s < QW; s++) begin
            lo_ff[s]   <= nst_pkg::div_step(lo_ff[s-1], den_ff[s-1]);
            hi_ff[s]   <= nst_pkg::div_step(hi_ff[s-1], den_ff[s-1]);
            den_ff[s]  <= den_ff[s-1];
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   assign out_valid = v_ff[QW-1];
   assign out_side  = side_ff[QW-1];
   assign out_q_lo  = lo_ff[QW-1].q;
   assign out_q_hi  = hi_ff[QW-1].q;

endmodule

// File: hdl/nine_slice_axis_tiler.sv
// ----------------------------------------------------------------------------
// nine_slice_axis_tiler: places border-image tiles along one axis.
// A setup sequencer works out tile count, width, pitch and start for each
// request beat; every tile then flows through clip, multiply, a pipelined
// divider and an output register, one tile per cycle while rsp is not stalled.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_ready   area, source slice, repeat mode
//   rsp      out        rsp_valid/rsp_ready   one clipped tile per beat
//
// A request beat is accepted, then runs up to two setup divisions (none for
// stretch, one or two otherwise) and, for repeat mode and a single space tile,
// a centring multiply and adjust, before its result beats are issued.
// Results leave through stages a, b, c, the divider stages and the output register.
// A new request is taken once the previous one has issued all its tiles.
// Reset is synchronous and clears all control state.
// A stall on rsp freezes the whole tile pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module nine_slice_axis_tiler #(
   parameter int MAX_TILES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [23:0] req_area_start,
   input  logic [22:0]        req_area_extent,
   input  logic [15:0]        req_src_start,
   input  logic [15:0]        req_src_extent,
   input  logic [1:0]         req_repeat_mode,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [23:0] rsp_dest_lo,
   output logic signed [23:0] rsp_dest_hi,
   output logic [23:0]        rsp_src_lo,
   output logic [23:0]        rsp_src_hi,
   output logic               rsp_empty_res,
   output logic               rsp_truncated,
   output logic               rsp_last
);

   localparam int            KW     = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
   localparam logic [KW-1:0] K_LAST = KW'(MAX_TILES - 1);
   localparam logic [15:0]   MAX16  = 16'(MAX_TILES);
   localparam int            SW     = nst_pkg::SDIV_W;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIV1  = 3'd1;
   localparam logic [2:0] ST_MUL   = 3'd2;
   localparam logic [2:0] ST_ADJ   = 3'd3;
   localparam logic [2:0] ST_DIV2  = 3'd4;
   localparam logic [2:0] ST_ISSUE = 3'd5;

   // Sequencer state and the placement of the current request.
   logic [2:0]         st_ff, st_in;
   logic [1:0]         mode_ff, mode_in;
   logic signed [31:0] x_ff, x_in;
   logic [22:0]        w_ff, w_in;
   logic [23:0]        s0_ff, s0_in;
   logic [23:0]        sx_ff, sx_in;
   logic [15:0]        count_ff, count_in;
   logic [23:0]        len_ff, len_in;
   logic [23:0]        pitch_ff, pitch_in;
   logic signed [31:0] tlo_ff, tlo_in;
   logic [KW-1:0]      k_ff, k_in;
   logic               empty_ff, empty_in;
   logic [39:0]        prod_ff, prod_in;

   logic               sd_start, sd_done;
   logic [SW-1:0]      sd_num, sd_den, sd_quo;
   logic [15:0]        q16, rcnt;
   logic [23:0]        p_s;
   logic signed [26:0] diff, half;
   logic               issue, is_last, ce;

   // Pipeline stages: issue (a), clip (b), multiply (c), output (o).
   logic                   a_v_ff;
   logic signed [31:0]     a_tlo_ff, a_x_ff, a_xw_ff;
   logic [23:0]            a_len_ff, a_s0_ff, a_sx_ff;
   logic                   a_last_ff, a_trunc_ff, a_empty_ff;

   logic signed [31:0]     b_thi, b_dlo, b_dhi0, b_dhi, b_lo_d, b_hi_d;
   logic                   b_v_ff;
   nst_pkg::tile_side_type b_side_ff, b_side_in;
   logic [23:0]            b_lo_off_ff, b_hi_off_ff, b_len_ff, b_sx_ff;

   logic                   c_v_ff;
   nst_pkg::tile_side_type c_side_ff;
   logic [23:0]            c_den_ff;
   logic [47:0]            c_nlo_ff, c_nhi_ff;

   logic                   d_v;
   nst_pkg::tile_side_type d_side;
   logic [nst_pkg::QW-1:0] d_qlo, d_qhi;

   logic                   o_v_ff;
   logic signed [23:0]     o_dlo_ff, o_dhi_ff;
   logic [23:0]            o_slo_ff, o_shi_ff;
   logic                   o_empty_ff, o_trunc_ff, o_last_ff;

   // The tile pipeline advances whenever the output register can move.
   assign ce        = !o_v_ff || rsp_ready;
   assign req_ready = (st_ff == ST_IDLE);

   nst_seq_div u_sdiv (
      .clock (clock),
      .reset (reset),
      .start (sd_start),
      .num   (sd_num),
      .den   (sd_den),
      .done  (sd_done),
      .quo   (sd_quo)
   );

   // Setup sequencer: count, width, pitch and start, then tile issue.
   always_comb begin
      st_in    = st_ff;
      mode_in  = mode_ff;
      x_in     = x_ff;
      w_in     = w_ff;
      s0_in    = s0_ff;
      sx_in    = sx_ff;
      count_in = count_ff;
      len_in   = len_ff;
      pitch_in = pitch_ff;
      tlo_in   = tlo_ff;
      k_in     = k_ff;
      empty_in = empty_ff;
      prod_in  = prod_ff;
      sd_start = 1'b0;
      sd_num   = '0;
      sd_den   = '0;
      issue    = 1'b0;
      p_s      = {8'h00, req_src_extent} << nst_pkg::FRAC_BITS;
      q16      = sd_quo[15:0];
      rcnt     = (q16 == 16'd0) ? 16'd1 : q16;
      diff     = $signed({4'b0000, w_ff}) - $signed({1'b0, prod_ff[25:0]});
      half     = diff >>> 1;
      is_last  = empty_ff || (16'(k_ff) == count_ff - 16'd1) || (k_ff == K_LAST);

      case (st_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in  = req_repeat_mode;
               x_in     = {{8{req_area_start[23]}}, req_area_start};
               tlo_in   = {{8{req_area_start[23]}}, req_area_start};
               w_in     = req_area_extent;
               s0_in    = {8'h00, req_src_start} << nst_pkg::FRAC_BITS;
               sx_in    = p_s;
               k_in     = '0;
               empty_in = 1'b0;
               if (p_s == 24'd0) begin
                  empty_in = 1'b1;
                  st_in    = ST_ISSUE;
               end else begin
                  case (req_repeat_mode)
                     nst_pkg::MODE_STRETCH: begin
                        count_in = 16'd1;
                        len_in   = {1'b0, req_area_extent};
                        pitch_in = {1'b0, req_area_extent};
                        st_in    = ST_ISSUE;
                     end
                     nst_pkg::MODE_REPEAT: begin
                        sd_start = 1'b1;
                        sd_num   = {2'b00, req_area_extent} + {1'b0, p_s} - 25'd1;
                        sd_den   = {1'b0, p_s};
                        st_in    = ST_DIV1;
                     end
                     nst_pkg::MODE_ROUND: begin
                        sd_start = 1'b1;
                        sd_num   = {1'b0, req_area_extent, 1'b0} + {1'b0, p_s};
                        sd_den   = {p_s, 1'b0};
                        st_in    = ST_DIV1;
                     end
                     default: begin
                        sd_start = 1'b1;
                        sd_num   = {2'b00, req_area_extent};
                        sd_den   = {1'b0, p_s};
                        st_in    = ST_DIV1;
                     end
                  endcase
               end
            end
         end
         ST_DIV1: begin
            if (sd_done) begin
               case (mode_ff)
                  nst_pkg::MODE_REPEAT: begin
                     count_in = q16;
                     len_in   = sx_ff;
                     pitch_in = sx_ff;
                     if (q16 == 16'd0) begin
                        empty_in = 1'b1;
                        st_in    = ST_ISSUE;
                     end else begin
                        st_in = ST_MUL;
                     end
                  end
                  nst_pkg::MODE_ROUND: begin
                     count_in = rcnt;
                     sd_start = 1'b1;
                     sd_num   = {2'b00, w_ff};
                     sd_den   = {9'd0, rcnt};
                     st_in    = ST_DIV2;
                  end
                  default: begin
                     // Space mode: a single tile is centred, several are spread.
                     count_in = q16;
                     len_in   = sx_ff;
                     pitch_in = sx_ff;
                     if (q16 == 16'd0) begin
                        empty_in = 1'b1;
                        st_in    = ST_ISSUE;
                     end else if (q16 == 16'd1) begin
                        st_in = ST_MUL;
                     end else begin
                        sd_start = 1'b1;
                        sd_num   = {2'b00, w_ff};
                        sd_den   = {9'd0, q16 - 16'd1};
                        st_in    = ST_DIV2;
                     end
                  end
               endcase
            end
         end
         ST_MUL: begin
            prod_in = count_ff * sx_ff;
            st_in   = ST_ADJ;
         end
         ST_ADJ: begin
            tlo_in = x_ff + {{5{half[26]}}, half};
            st_in  = ST_ISSUE;
         end
         ST_DIV2: begin
            if (sd_done) begin
               pitch_in = sd_quo[23:0];
               if (mode_ff == nst_pkg::MODE_ROUND) begin
                  len_in = sd_quo[23:0];
               end
               st_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (ce) begin
               issue  = 1'b1;
               tlo_in = tlo_ff + $signed({8'h00, pitch_ff});
               k_in   = k_ff + 1'b1;
               if (is_last) begin
                  st_in = ST_IDLE;
               end
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      x_ff     <= x_in;
      w_ff     <= w_in;
      s0_ff    <= s0_in;
      sx_ff    <= sx_in;
      count_ff <= count_in;
      len_ff   <= len_in;
      pitch_ff <= pitch_in;
      tlo_ff   <= tlo_in;
      k_ff     <= k_in;
      empty_ff <= empty_in;
      prod_ff  <= prod_in;
   end

   // Stage a: issued tile with its own copy of the placement.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (ce) begin
         a_v_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         a_tlo_ff   <= tlo_ff;
         a_x_ff     <= x_ff;
         a_xw_ff    <= x_ff + $signed({9'd0, w_ff});
         a_len_ff   <= len_ff;
         a_s0_ff    <= s0_ff;
         a_sx_ff    <= sx_ff;
         a_last_ff  <= is_last;
         a_trunc_ff <= is_last && !empty_ff && (count_ff > MAX16);
         a_empty_ff <= empty_ff;
      end
   end

   // Stage b: clip the tile to the area and find offsets into the tile.
   always_comb begin
      b_thi  = a_tlo_ff + $signed({8'h00, a_len_ff});
      b_dlo  = (a_tlo_ff > a_x_ff) ? a_tlo_ff : a_x_ff;
      b_dhi0 = (b_thi < a_xw_ff) ? b_thi : a_xw_ff;
      b_dhi  = (b_dhi0 < b_dlo) ? b_dlo : b_dhi0;
      b_lo_d = b_dlo - a_tlo_ff;
      b_hi_d = b_dhi - a_tlo_ff;
      b_side_in.dlo   = nst_pkg::sat_dest(b_dlo);
      b_side_in.dhi   = nst_pkg::sat_dest(b_dhi);
      b_side_in.s0    = a_s0_ff;
      b_side_in.last  = a_last_ff;
      b_side_in.trunc = a_trunc_ff;
      b_side_in.empty = a_empty_ff;
      b_side_in.lenz  = (a_len_ff == 24'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (ce) begin
         b_v_ff <= a_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         b_side_ff   <= b_side_in;
         b_lo_off_ff <= b_lo_d[23:0];
         b_hi_off_ff <= b_hi_d[23:0];
         b_len_ff    <= a_len_ff;
         b_sx_ff     <= a_sx_ff;
      end
   end

   // Stage c: scale both offsets by the source length.
   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else if (ce) begin
         c_v_ff <= b_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         c_side_ff <= b_side_ff;
         c_den_ff  <= b_len_ff;
         c_nlo_ff  <= {24'h000000, b_sx_ff} * {24'h000000, b_lo_off_ff};
         c_nhi_ff  <= {24'h000000, b_sx_ff} * {24'h000000, b_hi_off_ff};
      end
   end

   nst_div_pipe u_dpipe (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .in_valid  (c_v_ff),
      .in_side   (c_side_ff),
      .in_den    (c_den_ff),
      .in_num_lo (c_nlo_ff),
      .in_num_hi (c_nhi_ff),
      .out_valid (d_v),
      .out_side  (d_side),
      .out_q_lo  (d_qlo),
      .out_q_hi  (d_qhi)
   );

   // Output register: add the source start, saturate, handle special cases.
   always_ff @(posedge clock) begin
      if (reset) begin
         o_v_ff <= 1'b0;
      end else if (ce) begin
         o_v_ff <= d_v;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         o_empty_ff <= d_side.empty;
         o_trunc_ff <= d_side.trunc;
         o_last_ff  <= d_side.last;
         if (d_side.empty) begin
            o_dlo_ff <= '0;
            o_dhi_ff <= '0;
            o_slo_ff <= '0;
            o_shi_ff <= '0;
         end else begin
            o_dlo_ff <= d_side.dlo;
            o_dhi_ff <= d_side.dhi;
            if (d_side.lenz) begin
               o_slo_ff <= d_side.s0;
               o_shi_ff <= d_side.s0;
            end else begin
               o_slo_ff <= nst_pkg::sat_src(d_side.s0, d_qlo);
               o_shi_ff <= nst_pkg::sat_src(d_side.s0, d_qhi);
            end
         end
      end
   end

   assign rsp_valid     = o_v_ff;
   assign rsp_dest_lo   = o_dlo_ff;
   assign rsp_dest_hi   = o_dhi_ff;
   assign rsp_src_lo    = o_slo_ff;
   assign rsp_src_hi    = o_shi_ff;
   assign rsp_empty_res = o_empty_ff;
   assign rsp_truncated = o_trunc_ff;
   assign rsp_last      = o_last_ff;

endmodule

// File: hdl/nst_checker.sv
// ----------------------------------------------------------------------------
// nst_checker: port-level checks for the nine-slice axis tiler.
// Watches the result channel and checks beat framing, payload holding and interval direction.
// ----------------------------------------------------------------------------
module nst_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [23:0] rsp_dest_lo,
   input logic signed [23:0] rsp_dest_hi,
   input logic [23:0]        rsp_src_lo,
   input logic [23:0]        rsp_src_hi,
   input logic               rsp_empty_res,
   input logic               rsp_truncated,
   input logic               rsp_last
);

   // A stalled result beat stays valid and holds its dest_lo and src_hi fields.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dest_lo) && $stable(rsp_src_hi))
      else $error("result beat changed while stalled");

   // An empty result closes its request, is not truncated and has zero low coordinates.
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |-> rsp_last && !rsp_truncated &&
      rsp_dest_lo == 24'sd0 && rsp_src_lo == 24'd0)
      else $error("malformed empty result");

   // Truncation is flagged only on the closing beat.
   a_trunc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_truncated |-> rsp_last && !rsp_empty_res)
      else $error("truncation flag on a non-final beat");

   // Clipped intervals never run backwards.
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_dest_hi >= rsp_dest_lo && rsp_src_hi >= rsp_src_lo)
      else $error("tile interval reversed");

endmodule

bind nine_slice_axis_tiler nst_checker u_nst_checker (.*);

// File: test/nst_checker.sv
// ----------------------------------------------------------------------------
// nst_scoreboard: tile predictor and scoreboard for the nine-slice axis tiler.
// Watches both channels, works out the tiles of every accepted request beat
// and compares each result beat field by field with the oldest tile waiting.
// ----------------------------------------------------------------------------
module nst_scoreboard (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [23:0] req_area_start,
   input  logic [22:0]        req_area_extent,
   input  logic [15:0]        req_src_start,
   input  logic [15:0]        req_src_extent,
   input  logic [1:0]         req_repeat_mode,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [23:0] rsp_dest_lo,
   input  logic signed [23:0] rsp_dest_hi,
   input  logic [23:0]        rsp_src_lo,
   input  logic [23:0]        rsp_src_hi,
   input  logic               rsp_empty_res,
   input  logic               rsp_truncated,
   input  logic               rsp_last,
   output int                 fail_count,
   output int                 tiles_pending
);

   localparam int TILE_LIMIT = 64;

   typedef struct packed {
      logic signed [23:0] dest_lo;
      logic signed [23:0] dest_hi;
      logic [23:0]        src_lo;
      logic [23:0]        src_hi;
      logic               empty_res;
      logic               truncated;
      logic               last;
   } tile_type;

   tile_type tile_queue[$];

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // Halving that rounds towards minus infinity.
   function automatic longint halve_down(longint d);
      return d >= 0 ? d / 2 : -((-d + 1) / 2);
   endfunction

   function automatic tile_type make_tile(longint dlo, longint dhi, longint slo,
                                          longint shi, logic e, logic t, logic l);
      tile_type r;
      r.dest_lo   = 24'(clamp(dlo, -8388608, 8388607));
      r.dest_hi   = 24'(clamp(dhi, -8388608, 8388607));
      r.src_lo    = 24'(clamp(slo, 0, 16776960));
      r.src_hi    = 24'(clamp(shi, 0, 16776960));
      r.empty_res = e;
      r.truncated = t;
      r.last      = l;
      return r;
   endfunction

   // Places the tiles of one request beat and queues the results it yields.
   task automatic place_tiles(logic signed [23:0] area_start, logic [22:0] area_extent,
                              logic [15:0] src_start, logic [15:0] src_extent,
                              logic [1:0] mode);
      longint x, w, s0, sl, start, len, pitch, count, emit, tlo, thi, dlo, dhi, slo, shi;
      bit cut;
      x = area_start;
      w = area_extent;
      s0 = longint'(src_start) << nst_pkg::FRAC_BITS;
      sl = longint'(src_extent) << nst_pkg::FRAC_BITS;
      start = x;
      len = 0;
      count = 0;
      if (sl > 0) begin
         case (mode)
            nst_pkg::MODE_STRETCH: begin
               len = w;
               count = 1;
            end
            nst_pkg::MODE_REPEAT: begin
               count = (w + sl - 1) / sl;
               len = sl;
               start = x + halve_down(w - count * sl);
            end
            nst_pkg::MODE_ROUND: begin
               count = (2 * w + sl) / (2 * sl);
               if (count < 1) count = 1;
               len = w / count;
            end
            default: begin
               count = w / sl;
               len = sl;
               if (count == 1) start = x + halve_down(w - sl);
            end
         endcase
      end
      pitch = len;
      if (sl > 0 && mode == nst_pkg::MODE_SPACE && count > 1) pitch = w / (count - 1);
      if (count <= 0) begin
         tile_queue.push_back(make_tile(0, 0, 0, 0, 1'b1, 1'b0, 1'b1));
      end else begin
         cut = count > TILE_LIMIT;
         emit = cut ? TILE_LIMIT : count;
         for (longint k = 0; k < emit; k++) begin
            tlo = start + pitch * k;
            thi = tlo + len;
            dlo = tlo > x ? tlo : x;
            dhi = thi < x + w ? thi : x + w;
            if (dhi < dlo) dhi = dlo;
            slo = s0;
            shi = s0;
            if (len > 0) begin
               slo = s0 + (sl * (dlo - tlo)) / len;
               shi = s0 + (sl * (dhi - tlo)) / len;
            end
            tile_queue.push_back(make_tile(dlo, dhi, slo, shi, 1'b0,
                                           cut && k == emit - 1, k == emit - 1));
         end
      end
   endtask

   // Predict on every request beat and compare on every result beat.
   always @(posedge clock) begin
      tile_type seen, want;
      if (reset) begin
         tile_queue.delete();
         fail_count <= 0;
         tiles_pending <= 0;
      end else begin
         if (req_valid && req_ready) begin
            place_tiles(req_area_start, req_area_extent, req_src_start,
                        req_src_extent, req_repeat_mode);
         end
         if (rsp_valid && rsp_ready) begin
            seen = '{rsp_dest_lo, rsp_dest_hi, rsp_src_lo, rsp_src_hi,
                     rsp_empty_res, rsp_truncated, rsp_last};
            if (tile_queue.size() == 0) begin
               $display("%0t: result beat with none expected: %p", $time, seen);
               fail_count <= fail_count + 1;
            end else begin
               want = tile_queue.pop_front();
               if (seen !== want) begin
                  $display("%0t: tile mismatch: expected %p, actual %p", $time, want, seen);
                  fail_count <= fail_count + 1;
               end
            end
         end
         tiles_pending <= tile_queue.size();
      end
   end

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb: top-level testbench for the nine-slice axis tiler.
// Drives a directed set of regions and then random ones, with random gaps on
// the request side and random stalls on the result side; a separate checker
// predicts every tile and counts mismatches, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;

   localparam int RANDOM_BEATS = 350;
   localparam int CYCLE_LIMIT  = 2000000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [23:0] req_area_start = '0;
   logic [22:0]        req_area_extent = '0;
   logic [15:0]        req_src_start = '0;
   logic [15:0]        req_src_extent = '0;
   logic [1:0]         req_repeat_mode = nst_pkg::MODE_STRETCH;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [23:0] rsp_dest_lo, rsp_dest_hi;
   logic [23:0]        rsp_src_lo, rsp_src_hi;
   logic               rsp_empty_res, rsp_truncated, rsp_last;
   int                 fail_count, tiles_pending;
   int                 cycle_count = 0;
   bit                 busy_phase = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   nine_slice_axis_tiler dut (.*);
   nst_scoreboard u_checker (.*);

   // Run-away guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** nine_slice_axis_tiler: FAILED **");
         $finish;
      end
   end

   // Idle cycles before a beat; none at all during busy phases.
   function automatic int idle_cycles();
      return busy_phase ? 0 : $urandom_range(0, 12);
   endfunction

   // Result side: stall a random number of cycles before each beat.
   initial begin
      int n;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         n = idle_cycles();
         if (n > 0) begin
            rsp_ready = 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Sends one request beat, holding it until it is accepted.
   task automatic send_region(logic signed [23:0] a0, logic [22:0] aw, logic [15:0] s0,
                              logic [15:0] sw, logic [1:0] mode);
      int n;
      n = idle_cycles();
      if (n > 0) begin
         req_valid = 1'b0;
         repeat (n) @(negedge clock);
      end
      req_valid = 1'b1;
      req_area_start = a0;
      req_area_extent = aw;
      req_src_start = s0;
      req_src_extent = sw;
      req_repeat_mode = mode;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   initial begin
      logic [15:0] sw;
      logic [22:0] aw;
      int shape;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Directed regions: each mode, empty source, zero count, truncation,
      // centred single tiles and saturation at the extremes.
      send_region(24'sd1000, 23'd5000, 16'd10, 16'd20, nst_pkg::MODE_STRETCH);
      send_region(24'sd0, 23'd2560, 16'd3, 16'd3, nst_pkg::MODE_REPEAT);
      send_region(-24'sd500, 23'd2700, 16'd0, 16'd4, nst_pkg::MODE_ROUND);
      send_region(24'sd256, 23'd3000, 16'd7, 16'd2, nst_pkg::MODE_SPACE);
      send_region(24'sd100, 23'd4000, 16'd5, 16'd0, nst_pkg::MODE_REPEAT);
      send_region(24'sd0, 23'd200, 16'd1, 16'd2, nst_pkg::MODE_SPACE);
      send_region(24'sd0, 23'd700, 16'd1, 16'd2, nst_pkg::MODE_SPACE);
      send_region(24'sd0, 23'd0, 16'd1, 16'd2, nst_pkg::MODE_STRETCH);
      send_region(24'sd0, 23'd0, 16'd1, 16'd2, nst_pkg::MODE_ROUND);
      send_region(24'sd0, 23'd0, 16'd1, 16'd2, nst_pkg::MODE_REPEAT);
      send_region(24'sd50, 23'd25600, 16'd9, 16'd1, nst_pkg::MODE_REPEAT);
      send_region(24'sd50, 23'd16384, 16'd9, 16'd1, nst_pkg::MODE_ROUND);
      send_region(24'sd50, 23'd16384, 16'd9, 16'd1, nst_pkg::MODE_SPACE);
      send_region(24'sh800000, 23'h7FFFFF, 16'hFFFF, 16'hFFFF, nst_pkg::MODE_STRETCH);
      send_region(24'sd8388607, 23'h7FFFFF, 16'hFFFF, 16'hFFFF, nst_pkg::MODE_REPEAT);
      send_region(24'sh800000, 23'h7FFFFF, 16'hFFFF, 16'd1, nst_pkg::MODE_REPEAT);
      send_region(24'sd8388607, 23'h7FFFFF, 16'h0000, 16'hFFFF, nst_pkg::MODE_ROUND);
      send_region(-24'sd1, 23'h7FFFFF, 16'hFFFF, 16'hFFFF, nst_pkg::MODE_SPACE);
      send_region(24'sd1, 23'd1, 16'd1, 16'd1, nst_pkg::MODE_ROUND);
      send_region(24'sd0, 23'd383, 16'd0, 16'd1, nst_pkg::MODE_ROUND);

      // Random regions, mostly with tile counts in the interesting range.
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         if (i % 60 == 30) busy_phase = 1'b1;
         if (i % 60 == 45) busy_phase = 1'b0;
         shape = $urandom_range(0, 9);
         if (shape < 2) begin
            sw = 16'($urandom);
            aw = 23'($urandom);
         end else if (shape < 8) begin
            sw = 16'($urandom_range(1, 40));
            aw = 23'($urandom_range(0, (32'(sw) << nst_pkg::FRAC_BITS) * 72));
         end else begin
            sw = 16'($urandom_range(0, 3));
            aw = 23'($urandom_range(0, 2000));
         end
         send_region(24'($urandom), aw, 16'($urandom), sw, 2'($urandom_range(0, 3)));
      end
      req_valid = 1'b0;

      while (tiles_pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (fail_count == 0) begin
         $display("** nine_slice_axis_tiler: PASSED **");
      end else begin
         $display("** nine_slice_axis_tiler: FAILED **");
      end
      $finish;
   end

endmodule
